/* rtl/sst_pkg.sv */
// Package for the strongest-signal scan table.
// Holds the request codes, the transfer payload types, the table entry type and the
// controller state type. It depends on nothing else.
package sst_pkg;

	localparam int TABLE_ENTRIES_DEF = 8;
	localparam int ADDR_W = 48;
	localparam int RSSI_W = 8;

	typedef enum logic [1:0] {
		REQ_SCAN_START = 2'd0,
		REQ_ADV_REPORT = 2'd1,
		REQ_SCAN_DONE  = 2'd2,
		REQ_CLEAR      = 2'd3
	} req_code_t;

	typedef struct packed {
		req_code_t                  req_type;
		logic [1:0]                 peer_addr_type;
		logic [ADDR_W-1:0]          peer_address;
		logic signed [RSSI_W-1:0]   report_rssi;
		logic                       connectable_report;
	} req_item_t;

	typedef struct packed {
		logic                       entry_valid;
		logic [1:0]                 entry_addr_type;
		logic [ADDR_W-1:0]          entry_address;
		logic signed [RSSI_W-1:0]   entry_rssi;
		logic                       entry_connectable;
		logic                       last_entry;
	} rsp_item_t;

	typedef struct packed {
		logic [1:0]                 addr_type;
		logic [ADDR_W-1:0]          address;
		logic signed [RSSI_W-1:0]   rssi;
		logic                       connectable;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_DECIDE,
		S_SORT_LD,
		S_SORT_CAP,
		S_SORT_J,
		S_SORT_WB,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMPTY
	} state_t;

endpackage

/* rtl/strongest_signal_scan_table.sv */
// Strongest-signal scan table, top level. Uses sst_pkg and sst_table_mem.
//
// Requests arrive on the req channel (valid/ready); listing results leave on the
// rsp channel (valid/ready) through an output register. Scan start, clear and
// ignored reports finish in the idle state. An advertising report reads the table one
// entry per cycle through the single memory read port, then makes at most one
// write. A scan complete exchange-sorts the table in the memory in n - 1 passes
// for n stored entries. It then lists the entries, each read from the memory and
// then loaded into the output register, or gives one invalid last result
// when the table is empty. The block takes one request at a time: req_ready is
// high only while no request is in progress. A stalled receiver holds the
// listing at the output register and the listing resumes when the transfer
// completes. Reset empties the table through its fill count and disarms
// scanning; the memory itself is not cleared.
module strongest_signal_scan_table import sst_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	state_t                 state_q, state_d;
	logic [CW-1:0]          cnt_q;
	logic                   scan_q;
	req_item_t              item_q;
	logic [CW-1:0]          idx_q;
	logic                   v_s1;
	logic [IW-1:0]          idx_s1;
	logic [IW-1:0]          min_idx_q;
	logic signed [RSSI_W-1:0] min_rssi_q;
	logic [IW-1:0]          si_q;
	logic [IW-1:0]          ek_q;
	entry_t                 cur_q;
	logic                   out_valid_q;
	rsp_item_t              out_q;

	logic                   mem_we, mem_re;
	logic [IW-1:0]          mem_wa, mem_ra;
	entry_t                 mem_wd, rd_data;

	logic                   match_c, more_c, out_free, last_c, full_c, stronger_c;
	logic                   out_load_c;

	sst_table_mem #(
		.DEPTH(TABLE_ENTRIES),
		.IW(IW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_wa),
		.wdata(mem_wd),
		.re(mem_re),
		.raddr(mem_ra),
		.rdata(rd_data)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	assign match_c = v_s1 && (rd_data.addr_type == item_q.peer_addr_type)
		&& (rd_data.address == item_q.peer_address);
	assign more_c = (idx_q < cnt_q);
	assign out_free = !out_valid_q || rsp_ready;
	assign last_c = (CW'(ek_q) == (cnt_q - CW'(1)));
	assign full_c = (cnt_q >= CW'(TABLE_ENTRIES));
	assign stronger_c = $signed(rd_data.rssi) > $signed(cur_q.rssi);
	assign out_load_c = ((state_q == S_EMIT_LD) || (state_q == S_EMPTY)) && out_free;

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req.req_type)
						REQ_ADV_REPORT: begin
							if (scan_q) begin
								state_d = S_SRCH;
							end
						end
						REQ_SCAN_DONE: begin
							if (cnt_q == '0) begin
								state_d = S_EMPTY;
							end else if (cnt_q == CW'(1)) begin
								state_d = S_EMIT_RD;
							end else begin
								state_d = S_SORT_LD;
							end
						end
						default: ;
					endcase
				end
			end
			S_SRCH: begin
				if (match_c) begin
					mem_we = 1'b1;
					mem_wa = idx_s1;
					mem_wd.addr_type = item_q.peer_addr_type;
					mem_wd.address = item_q.peer_address;
					mem_wd.rssi = item_q.report_rssi;
					mem_wd.connectable = rd_data.connectable | item_q.connectable_report;
					state_d = S_IDLE;
				end else if (more_c) begin
					mem_re = 1'b1;
					mem_ra = idx_q[IW-1:0];
				end else if (!v_s1) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				mem_wd.addr_type = item_q.peer_addr_type;
				mem_wd.address = item_q.peer_address;
				mem_wd.rssi = item_q.report_rssi;
				mem_wd.connectable = item_q.connectable_report;
				if (!full_c) begin
					mem_we = 1'b1;
					mem_wa = cnt_q[IW-1:0];
				end else if ($signed(item_q.report_rssi) > $signed(min_rssi_q)) begin
					mem_we = 1'b1;
					mem_wa = min_idx_q;
				end
				state_d = S_IDLE;
			end
			S_SORT_LD: begin
				mem_re = 1'b1;
				mem_ra = si_q;
				state_d = S_SORT_CAP;
			end
			S_SORT_CAP: begin
				state_d = S_SORT_J;
			end
			S_SORT_J: begin
				if (v_s1 && stronger_c) begin
					mem_we = 1'b1;
					mem_wa = idx_s1;
					mem_wd = cur_q;
				end
				if (more_c) begin
					mem_re = 1'b1;
					mem_ra = idx_q[IW-1:0];
				end else if (!v_s1) begin
					state_d = S_SORT_WB;
				end
			end
			S_SORT_WB: begin
				mem_we = 1'b1;
				mem_wa = si_q;
				mem_wd = cur_q;
				if ((CW'(si_q) + CW'(2)) >= cnt_q) begin
					state_d = S_EMIT_RD;
				end else begin
					state_d = S_SORT_LD;
				end
			end
			S_EMIT_RD: begin
				mem_re = 1'b1;
				mem_ra = ek_q;
				state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (out_free) begin
					state_d = last_c ? S_IDLE : S_EMIT_RD;
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			scan_q <= 1'b0;
			idx_q <= '0;
			v_s1 <= 1'b0;
			si_q <= '0;
			ek_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= mem_re && ((state_q == S_SRCH) || (state_q == S_SORT_J));
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						idx_q <= '0;
						si_q <= '0;
						ek_q <= '0;
						case (req.req_type)
							REQ_SCAN_START: begin
								cnt_q <= '0;
								scan_q <= 1'b1;
							end
							REQ_CLEAR: begin
								cnt_q <= '0;
							end
							REQ_SCAN_DONE: begin
								scan_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_SRCH: begin
					if (mem_re) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DECIDE: begin
					if (!full_c) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_SORT_CAP: begin
					idx_q <= CW'(si_q) + CW'(1);
				end
				S_SORT_J: begin
					if (mem_re) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SORT_WB: begin
					si_q <= si_q + IW'(1);
				end
				S_EMIT_LD: begin
					if (out_free) begin
						if (!last_c) begin
							ek_q <= ek_q + IW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
		end
		if (mem_re) begin
			idx_s1 <= mem_ra;
		end
		if ((state_q == S_SRCH) && v_s1 && !match_c) begin
			if ((idx_s1 == '0) || ($signed(rd_data.rssi) < $signed(min_rssi_q))) begin
				min_idx_q <= idx_s1;
				min_rssi_q <= rd_data.rssi;
			end
		end
		if (state_q == S_SORT_CAP) begin
			cur_q <= rd_data;
		end
		if ((state_q == S_SORT_J) && v_s1 && stronger_c) begin
			cur_q <= rd_data;
		end
		if ((state_q == S_EMIT_LD) && out_free) begin
			out_q.entry_valid <= 1'b1;
			out_q.entry_addr_type <= rd_data.addr_type;
			out_q.entry_address <= rd_data.address;
			out_q.entry_rssi <= rd_data.rssi;
			out_q.entry_connectable <= rd_data.connectable;
			out_q.last_entry <= last_c;
		end
		if ((state_q == S_EMPTY) && out_free) begin
			out_q.entry_valid <= 1'b0;
			out_q.entry_addr_type <= '0;
			out_q.entry_address <= '0;
			out_q.entry_rssi <= '0;
			out_q.entry_connectable <= 1'b0;
			out_q.last_entry <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_ENTRIES))
		else $error("fill count exceeds table depth");

	a_scan_done_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req.req_type == REQ_SCAN_DONE)) |=> !scan_q)
		else $error("scan still armed after scan complete");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SRCH) || (state_q == S_SORT_J)) |-> (idx_q <= cnt_q))
		else $error("read index ran past the fill count");

	a_no_load_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp_ready) |=> out_valid_q && $stable(out_q))
		else $error("output register changed while the receiver stalled");
`endif

endmodule

/* rtl/sst_table_mem.sv */
// Peer table storage: one write port and one read port with a registered read.
// Uses the entry type from sst_pkg.
module sst_table_mem import sst_pkg::*; #(
	parameter int DEPTH = TABLE_ENTRIES_DEF,
	parameter int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
